[src/ips_pkg.sv]
// shared types, register codes and constants for the incremental pid step
package ips_pkg;

  // field widths
  localparam int DATA_W    = 16;
  localparam int ERR_W     = DATA_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 3;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_SET_POINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_TERM_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_TERM_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX      = 3'd7;

  // boost override
  localparam logic signed [ERR_W-1:0]  BOOST_ERR_LIMIT = 17'sd15;
  localparam logic signed [DATA_W-1:0] BOOST_DRIVE     = 16'sd10000;

  // output saturation bounds
  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ERR_W-1:0]  err_t;

  // configuration bundle handed from the register file to the datapath
  typedef struct packed {
    data_t set_point;
    data_t gain_prop;
    data_t gain_integ;
    data_t gain_deriv;
    data_t integ_term_min;
    data_t integ_term_max;
    data_t drive_min;
    data_t drive_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    set_point:      16'sd0,
    gain_prop:      16'sd0,
    gain_integ:     16'sd0,
    gain_deriv:     16'sd0,
    integ_term_min: DATA_MIN,
    integ_term_max: DATA_MAX,
    drive_min:      DATA_MIN,
    drive_max:      DATA_MAX
  };

endpackage

[src/ips_cfg_regs.sv]
// configuration register file for the incremental pid step
module ips_cfg_regs
  import ips_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SET_POINT:      cfg_nxt.set_point      = cfg_wdata;
        REG_GAIN_PROP:      cfg_nxt.gain_prop      = cfg_wdata;
        REG_GAIN_INTEG:     cfg_nxt.gain_integ     = cfg_wdata;
        REG_GAIN_DERIV:     cfg_nxt.gain_deriv     = cfg_wdata;
        REG_INTEG_TERM_MIN: cfg_nxt.integ_term_min = cfg_wdata;
        REG_INTEG_TERM_MAX: cfg_nxt.integ_term_max = cfg_wdata;
        REG_DRIVE_MIN:      cfg_nxt.drive_min      = cfg_wdata;
        REG_DRIVE_MAX:      cfg_nxt.drive_max      = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/ips_core.sv]
// combinational pid delta, integral clamp and drive accumulation
module ips_core
  import ips_pkg::*;
(
  input  cfg_t  cfg,
  input  err_t  err_new,
  input  err_t  err_prior,
  input  err_t  err_last2,
  input  data_t accum,
  input  logic  boost,
  output data_t drive
);

  logic signed [ERR_W:0]   diff_p;
  logic signed [ERR_W+1:0] diff_d;
  logic signed [33:0]      term_p;
  logic signed [32:0]      term_i;
  logic signed [34:0]      term_d;
  logic signed [32:0]      integ_lo;
  logic signed [32:0]      integ_hi;
  logic signed [32:0]      term_i_c;
  logic signed [36:0]      delta_q8;
  logic signed [36:0]      delta_trunc;
  logic                    round_up;
  data_t                   delta;
  logic signed [DATA_W:0]  acc_sum;
  data_t                   acc_clamp;

  // first and second differences of the error
  assign diff_p = (ERR_W+1)'(err_new) - (ERR_W+1)'(err_prior);
  assign diff_d = (ERR_W+2)'(err_new) - (ERR_W+2)'(err_prior) - (ERR_W+2)'(err_prior)
                + (ERR_W+2)'(err_last2);

  // gain products in q.8
  assign term_p = cfg.gain_prop  * diff_p;
  assign term_i = cfg.gain_integ * err_new;
  assign term_d = cfg.gain_deriv * diff_d;

  // integral clamp, lower limit tested first
  assign integ_lo = 33'($signed({cfg.integ_term_min, 8'd0}));
  assign integ_hi = 33'($signed({cfg.integ_term_max, 8'd0}));

  always_comb begin
    if (term_i < integ_lo) begin
      term_i_c = integ_lo;
    end else if (term_i > integ_hi) begin
      term_i_c = integ_hi;
    end else begin
      term_i_c = term_i;
    end
  end

  // sum and divide by 256 toward zero
  assign delta_q8    = 37'(term_p) + 37'(term_i_c) + 37'(term_d);
  assign round_up    = delta_q8[36] && (|delta_q8[FRAC_BITS-1:0]);
  assign delta_trunc = (delta_q8 >>> FRAC_BITS) + $signed(37'(round_up));

  // saturate delta to the output width
  always_comb begin
    if (delta_trunc < 37'(DATA_MIN)) begin
      delta = DATA_MIN;
    end else if (delta_trunc > 37'(DATA_MAX)) begin
      delta = DATA_MAX;
    end else begin
      delta = delta_trunc[DATA_W-1:0];
    end
  end

  // accumulate and clamp to drive limits, lower limit first
  assign acc_sum = (DATA_W+1)'(accum) + (DATA_W+1)'(delta);

  always_comb begin
    if (acc_sum < (DATA_W+1)'(cfg.drive_min)) begin
      acc_clamp = cfg.drive_min;
    end else if (acc_sum > (DATA_W+1)'(cfg.drive_max)) begin
      acc_clamp = cfg.drive_max;
    end else begin
      acc_clamp = acc_sum[DATA_W-1:0];
    end
  end

  // boost override on large positive error
  assign drive = (boost && (err_new > BOOST_ERR_LIMIT)) ? BOOST_DRIVE : acc_clamp;

endmodule

[src/incremental_pid_step.sv]
// top level of the incremental pid step
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_measured, in_boost_enable
//   out      output     out_valid / out_stall out_drive
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle sustained while out_stall is low; an item sits in the input
// register after the edge that accepts it and its drive moves on to the result
// register, with the whole pid update between them as one pass that also
// updates the error history and the drive accumulator. synchronous active-low
// reset clears the error history, the accumulator and both valid flags. in_stall
// rises only when a held item waits behind a result that out_stall is holding.
module incremental_pid_step
  import ips_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_measured,
  input  logic                 in_boost_enable,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_drive,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  cfg_t  cfg;
  logic  in_take;
  logic  advance;
  data_t drive_calc;

  logic  s1_valid_r, s1_valid_nxt;
  err_t  s1_err_r,   s1_err_nxt;
  logic  s1_boost_r, s1_boost_nxt;
  err_t  err_now_r,  err_now_nxt;
  err_t  err_prev_r, err_prev_nxt;
  data_t accum_r,    accum_nxt;
  logic  out_valid_r, out_valid_nxt;
  data_t out_drive_r, out_drive_nxt;

  ips_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // input register holds the fresh error
  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    s1_err_nxt   = s1_err_r;
    s1_boost_nxt = s1_boost_r;
    if (in_take) begin
      s1_err_nxt   = (ERR_W)'(cfg.set_point) - (ERR_W)'($signed(in_measured));
      s1_boost_nxt = in_boost_enable;
    end
  end

  ips_core u_core (
    .cfg       (cfg),
    .err_new   (s1_err_r),
    .err_prior (err_now_r),
    .err_last2 (err_prev_r),
    .accum     (accum_r),
    .boost     (s1_boost_r),
    .drive     (drive_calc)
  );

  // state and result update when the item moves to the result register
  always_comb begin
    err_now_nxt   = err_now_r;
    err_prev_nxt  = err_prev_r;
    accum_nxt     = accum_r;
    out_drive_nxt = out_drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      err_now_nxt   = s1_err_r;
      err_prev_nxt  = err_now_r;
      accum_nxt     = drive_calc;
      out_drive_nxt = drive_calc;
      out_valid_nxt = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_now_r   <= '0;
      err_prev_r  <= '0;
      accum_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      err_now_r   <= err_now_nxt;
      err_prev_r  <= err_prev_nxt;
      accum_r     <= accum_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_err_r    <= s1_err_nxt;
    s1_boost_r  <= s1_boost_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule

[src/ips_checker.sv]
// port-level checks for the incremental pid step and their bind
module ips_checker
  import ips_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DATA_W-1:0]    out_drive
);

  // reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall set after reset");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // an accepted item reaches the output if out_stall is low while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive))
    else $error("stalled result changed");

endmodule

bind incremental_pid_step ips_checker u_ips_checker (.*);
